FILE: rtl/shared_line_socket_manager_defines.svh
// Assertion macros used by the RTL file shared_line_socket_manager.sv.
`ifndef SHARED_LINE_SOCKET_MANAGER_DEFINES_SVH
`define SHARED_LINE_SOCKET_MANAGER_DEFINES_SVH

`ifndef SYNTHESIS

`define SLSM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("slsm assertion failed");

`define SLSM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("slsm assertion failed");

`else

`define SLSM_ASSERT(lbl, clk, rst_n, prop)

`define SLSM_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: rtl/slsm_pkg.sv
package slsm_pkg;

  localparam int unsigned SOCK_MAX = 8;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned CFG_W    = 32;

  typedef enum logic [1:0] {
    SOCK_OFF     = 2'd0,
    SOCK_ON      = 2'd1,
    SOCK_BLOCKED = 2'd2
  } sock_state_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_OFF   = 2'd1,
    STAT_LINE_BUSY = 2'd2,
    STAT_NOT_ON    = 2'd3
  } status_t;

  typedef enum logic {
    KIND_PLUG   = 1'b0,
    KIND_UNPLUG = 1'b1
  } kind_t;

  typedef struct packed {
    status_t             status;
    sock_state_t         sel_state;
    logic [CFG_W-1:0]    busy;
    logic [SOCK_MAX-1:0] on_mask;
    logic [SOCK_MAX-1:0] blk_mask;
  } step_t;

endpackage

FILE: rtl/shared_line_socket_manager.sv
// An accepted request is held in the input register; its result then goes to the output register.
// Throughput: one request per cycle unless out_ready stalls the output register; the socket
// state and busy-line mask update as a request moves from the input register into the result register.
// Reset (rst_n low, synchronous): all sockets off, all lines free, line masks zero,
// both pipeline registers empty.
`include "shared_line_socket_manager_defines.svh"

module shared_line_socket_manager #(
  parameter int unsigned SOCKETS = 8,
  parameter int unsigned LINES   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [2:0]  in_socket_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [1:0]  out_socket_state,
  output logic [31:0] out_busy_lines,
  output logic [7:0]  out_on_sockets,
  output logic [7:0]  out_blocked_sockets
);

  localparam logic [63:0] LINE_MASK64 = (64'd1 << LINES) - 64'd1;
  localparam logic [slsm_pkg::CFG_W-1:0] LINE_MASK = LINE_MASK64[slsm_pkg::CFG_W-1:0];
  localparam logic [15:0] SOCK_MASK16 = (16'd1 << SOCKETS) - 16'd1;
  localparam logic [slsm_pkg::SOCK_MAX-1:0] SOCK_MASK =
    SOCK_MASK16[slsm_pkg::SOCK_MAX-1:0];

  logic [slsm_pkg::CFG_W-1:0]   cfg_lines_r [slsm_pkg::SOCK_MAX];
  logic [slsm_pkg::CFG_W-1:0]   lines_eff   [slsm_pkg::SOCK_MAX];
  slsm_pkg::sock_state_t        states_r    [slsm_pkg::SOCK_MAX];
  slsm_pkg::sock_state_t        states_nxt  [slsm_pkg::SOCK_MAX];
  logic [slsm_pkg::CFG_W-1:0]   busy_r;

  logic                         in_v_r;
  slsm_pkg::kind_t              kind_r;
  logic [slsm_pkg::IDX_W-1:0]   idx_r;

  logic                         out_v_r;
  slsm_pkg::step_t              res_r;
  slsm_pkg::step_t              res;

  logic                         adv;
  logic                         fire;

  assign cfg_ready = 1'b1;
  assign adv       = !out_v_r || out_ready;
  assign fire      = in_v_r && adv;
  assign in_ready  = !in_v_r || adv;

  always_comb begin
    for (int i = 0; i < slsm_pkg::SOCK_MAX; i++) begin
      lines_eff[i] = cfg_lines_r[i] & LINE_MASK;
    end
  end

  slsm_step #(
    .SOCKETS(SOCKETS)
  ) u_step (
    .kind       (kind_r),
    .idx        (idx_r),
    .states     (states_r),
    .lines      (lines_eff),
    .busy       (busy_r),
    .states_nxt (states_nxt),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < slsm_pkg::SOCK_MAX; i++) begin
        cfg_lines_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      cfg_lines_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < slsm_pkg::SOCK_MAX; i++) begin
        states_r[i] <= slsm_pkg::SOCK_OFF;
      end
      busy_r  <= '0;
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (fire) begin
        for (int i = 0; i < slsm_pkg::SOCK_MAX; i++) begin
          states_r[i] <= states_nxt[i];
        end
        busy_r <= res.busy;
      end
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (adv) begin
        out_v_r <= in_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= slsm_pkg::kind_t'(in_kind);
      idx_r  <= in_socket_index;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_v_r;
  assign out_status          = res_r.status;
  assign out_socket_state    = res_r.sel_state;
  assign out_busy_lines      = res_r.busy;
  assign out_on_sockets      = res_r.on_mask;
  assign out_blocked_sockets = res_r.blk_mask;

  `SLSM_ASSERT(a_busy_in_range, clk, rst_n, (busy_r & ~LINE_MASK) == '0)
  `SLSM_ASSERT(a_absent_sockets_idle, clk, rst_n,
    out_v_r |-> ((res_r.on_mask | res_r.blk_mask) & ~SOCK_MASK) == '0)
  `SLSM_ASSERT(a_refused_keeps_busy, clk, rst_n,
    (fire && res.status != slsm_pkg::STAT_OK) |=> $stable(busy_r))
  `SLSM_ASSERT(a_plug_turns_on, clk, rst_n,
    (fire && kind_r == slsm_pkg::KIND_PLUG && res.status == slsm_pkg::STAT_OK)
      |=> res_r.sel_state == slsm_pkg::SOCK_ON)
  `SLSM_ASSERT(a_stalled_input_holds, clk, rst_n,
    (in_v_r && !adv) |=> (in_v_r && $stable(idx_r) && $stable(kind_r)))

endmodule

FILE: rtl/slsm_step.sv
module slsm_step #(
  parameter int unsigned SOCKETS = 8
) (
  input  slsm_pkg::kind_t                kind,
  input  logic [slsm_pkg::IDX_W-1:0]     idx,
  input  slsm_pkg::sock_state_t          states   [slsm_pkg::SOCK_MAX],
  input  logic [slsm_pkg::CFG_W-1:0]     lines    [slsm_pkg::SOCK_MAX],
  input  logic [slsm_pkg::CFG_W-1:0]     busy,
  output slsm_pkg::sock_state_t          states_nxt [slsm_pkg::SOCK_MAX],
  output slsm_pkg::step_t                res
);

  logic                          present;
  logic [slsm_pkg::CFG_W-1:0]    sel_lines;
  logic [slsm_pkg::CFG_W-1:0]    busy_nxt;
  slsm_pkg::status_t             status;

  assign present   = {1'b0, idx} < 4'(SOCKETS);
  assign sel_lines = lines[idx];

  always_comb begin
    busy_nxt = busy;
    status   = slsm_pkg::STAT_OK;
    for (int i = 0; i < slsm_pkg::SOCK_MAX; i++) begin
      states_nxt[i] = states[i];
    end
    case (kind)
      slsm_pkg::KIND_PLUG: begin
        if (!present || states[idx] != slsm_pkg::SOCK_OFF) begin
          status = slsm_pkg::STAT_NOT_OFF;
        end else if ((sel_lines & busy) != '0) begin
          status = slsm_pkg::STAT_LINE_BUSY;
        end else begin
          busy_nxt = busy | sel_lines;
          for (int i = 0; i < slsm_pkg::SOCK_MAX; i++) begin
            if (i < SOCKETS) begin
              if (i == int'(idx)) begin
                states_nxt[i] = slsm_pkg::SOCK_ON;
              end else if (states[i] == slsm_pkg::SOCK_OFF &&
                           (lines[i] & busy_nxt) != '0) begin
                states_nxt[i] = slsm_pkg::SOCK_BLOCKED;
              end
            end
          end
        end
      end
      slsm_pkg::KIND_UNPLUG: begin
        if (!present || states[idx] != slsm_pkg::SOCK_ON) begin
          status = slsm_pkg::STAT_NOT_ON;
        end else begin
          busy_nxt = busy & ~sel_lines;
          for (int i = 0; i < slsm_pkg::SOCK_MAX; i++) begin
            if (i < SOCKETS) begin
              if (i == int'(idx)) begin
                states_nxt[i] = slsm_pkg::SOCK_OFF;
              end else if (states[i] == slsm_pkg::SOCK_BLOCKED &&
                           (lines[i] & busy_nxt) == '0) begin
                states_nxt[i] = slsm_pkg::SOCK_OFF;
              end
            end
          end
        end
      end
      default: begin
        status = slsm_pkg::STAT_OK;
      end
    endcase
  end

  always_comb begin
    res.status    = status;
    res.busy      = busy_nxt;
    res.sel_state = present ? states_nxt[idx] : slsm_pkg::SOCK_OFF;
    res.on_mask   = '0;
    res.blk_mask  = '0;
    for (int i = 0; i < slsm_pkg::SOCK_MAX; i++) begin
      if (i < SOCKETS) begin
        res.on_mask[i]  = (states_nxt[i] == slsm_pkg::SOCK_ON);
        res.blk_mask[i] = (states_nxt[i] == slsm_pkg::SOCK_BLOCKED);
      end
    end
  end

endmodule
